// File: design/prq_pkg.sv
// prq_pkg: shared types and constants of the priority ready queue
// no dependencies; imported by prq_ctrl, prq_datapath and priority_ready_queue

package prq_pkg;

   localparam int PID_W    = 12;
   localparam int PRI_W    = 8;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request word
      logic commit;    // update the queue and load the result register
   } prq_cmd_type;

endpackage

// File: design/priority_ready_queue.sv
// Priority ready queue of process ids, highest priority at the front (the running
// process). Each request word is an insert (placed by priority) or a remove of the
// front entry, and gives exactly one response word with the front id, a valid flag,
// the entry count and a status. A word is handled in steps: first the request is latched,
// then every queue cell compares its priority with the new one in parallel and
// shifts, holds or takes the new entry. A new request is taken while the last
// response still waits; a response that is not taken stalls the next word in its
// compare step. There is no clearing pass after reset.
// depends on prq_pkg, prq_ctrl and prq_datapath

module priority_ready_queue
   import prq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // process_id [11:0], priority_req [19:12], zero [23:20]
   input  logic        req_tuser,   // opcode [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // running_id [11:0], running_valid [12],
                                    // entry_count [17:13], status [19:18], zero [23:20]
);

   prq_cmd_type         cmd;
   logic [PID_W-1:0]    running_id;
   logic                running_valid;
   logic [COUNT_W-1:0]  entry_count;
   logic [STATUS_W-1:0] status;

   prq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   prq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .in_opcode         (req_tuser),
      .in_process_id     (req_tdata[11:0]),
      .in_priority_req   (req_tdata[19:12]),
      .out_running_id    (running_id),
      .out_running_valid (running_valid),
      .out_entry_count   (entry_count),
      .out_status        (status)
   );

   assign rsp_tdata = {4'b0000, status, entry_count, running_valid, running_id};

endmodule

// File: design/prq_ctrl.sv
// prq_ctrl: two-state sequencer and result valid flag of the queue
// depends on prq_pkg

module prq_ctrl
   import prq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output prq_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // the result register can be loaded when empty or drained this cycle
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == S_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign cmd.capture = req_tvalid && (state_ff == S_IDLE);
   assign cmd.commit  = (state_ff == S_EXEC) && out_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/prq_datapath.sv
// prq_datapath: shift-register queue cells, insert position compare and result register
// depends on prq_pkg; sequenced by prq_ctrl

module prq_datapath
   import prq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  prq_cmd_type         cmd,
   input  logic                in_opcode,
   input  logic [PID_W-1:0]    in_process_id,
   input  logic [PRI_W-1:0]    in_priority_req,
   output logic [PID_W-1:0]    out_running_id,
   output logic                out_running_valid,
   output logic [COUNT_W-1:0]  out_entry_count,
   output logic [STATUS_W-1:0] out_status
);

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   // latched request word
   logic             op_ff;
   logic [PID_W-1:0] pid_ff;
   logic [PRI_W-1:0] pri_ff;

   // queue cells, front at index 0, kept in non-increasing priority order
   logic [PID_W-1:0] q_id_ff  [QUEUE_DEPTH];
   logic [PRI_W-1:0] q_pri_ff [QUEUE_DEPTH];
   logic [PID_W-1:0] q_id_in  [QUEUE_DEPTH];
   logic [PRI_W-1:0] q_pri_in [QUEUE_DEPTH];

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PRI_W-1:0]  tail_pri_ff, tail_pri_in;

   logic [PID_W-1:0]    res_id_ff;
   logic                res_valid_ff;
   logic [COUNT_W-1:0]  res_count_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [STATUS_W-1:0] status_in;

   logic empty, full, front_ins, tail_ins, do_insert, do_remove;
   // at_or_after[i]: the new word lands at index i or earlier
   logic [QUEUE_DEPTH-1:0] at_or_after;

   assign empty     = (fill_ff == '0);
   assign full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign front_ins = empty || (pri_ff >= q_pri_ff[0]);
   assign tail_ins  = (pri_ff <= tail_pri_ff);
   assign do_insert = (op_ff == OP_INSERT) && !full;
   assign do_remove = (op_ff == OP_REMOVE) && !empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic             beyond;
      logic             le_new;
      logic             prev_ab;
      logic [PID_W-1:0] prev_id;
      logic [PRI_W-1:0] prev_pri;
      logic [PID_W-1:0] next_id;
      logic [PRI_W-1:0] next_pri;

      assign beyond = (FILL_W'(i) >= fill_ff);
      assign le_new = (i != 0) && (q_pri_ff[i] <= pri_ff);

      always_comb begin
         priority if (front_ins) begin
            at_or_after[i] = 1'b1;
         end else if (tail_ins) begin
            at_or_after[i] = beyond;
         end else begin
            // sorted order makes the compare flags a thermometer code
            at_or_after[i] = beyond || le_new;
         end
      end

      if (i == 0) begin : g_front
         assign prev_ab  = 1'b0;
         assign prev_id  = pid_ff;
         assign prev_pri = pri_ff;
      end else begin : g_inner
         assign prev_ab  = at_or_after[i-1];
         assign prev_id  = q_id_ff[i-1];
         assign prev_pri = q_pri_ff[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_id  = q_id_ff[i];
         assign next_pri = q_pri_ff[i];
      end else begin : g_body
         assign next_id  = q_id_ff[i+1];
         assign next_pri = q_pri_ff[i+1];
      end

      always_comb begin
         q_id_in[i]  = q_id_ff[i];
         q_pri_in[i] = q_pri_ff[i];
         if (do_insert && at_or_after[i]) begin
            if (prev_ab) begin
               q_id_in[i]  = prev_id;
               q_pri_in[i] = prev_pri;
            end else begin
               q_id_in[i]  = pid_ff;
               q_pri_in[i] = pri_ff;
            end
         end else if (do_remove) begin
            q_id_in[i]  = next_id;
            q_pri_in[i] = next_pri;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.commit) begin
            q_id_ff[i]  <= q_id_in[i];
            q_pri_ff[i] <= q_pri_in[i];
         end
      end
   end

   always_comb begin
      fill_in     = fill_ff;
      tail_pri_in = tail_pri_ff;
      status_in   = STATUS_OK;
      if (op_ff == OP_INSERT) begin
         if (full) begin
            status_in = STATUS_FULL;
         end else begin
            fill_in = fill_ff + FILL_W'(1);
            if (empty || (!front_ins && tail_ins)) begin
               tail_pri_in = pri_ff;
            end
         end
      end else begin
         if (empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            fill_in = fill_ff - FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= in_opcode;
         pid_ff <= in_process_id;
         pri_ff <= in_priority_req;
      end
      if (cmd.commit) begin
         tail_pri_ff   <= tail_pri_in;
         res_id_ff     <= (fill_in != '0) ? q_id_in[0] : '0;
         res_valid_ff  <= (fill_in != '0);
         res_count_ff  <= COUNT_W'(fill_in);
         res_status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.commit) begin
         fill_ff <= fill_in;
      end
   end

   assign out_running_id    = res_id_ff;
   assign out_running_valid = res_valid_ff;
   assign out_entry_count   = res_count_ff;
   assign out_status        = res_status_ff;

endmodule
